FILE: hdl/lcdseq_pkg.sv
package lcdseq_pkg;

	typedef enum logic [2:0] {
		ACT_INIT    = 3'd0,
		ACT_CMD     = 3'd1,
		ACT_DATA    = 3'd2,
		ACT_CLEAR   = 3'd3,
		ACT_POS     = 3'd4,
		ACT_POS_CUR = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		CFG_POWER_UP = 2'd0,
		CFG_PULSE    = 2'd1,
		CFG_GAP      = 2'd2,
		CFG_SETTLE   = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] POWER_UP_RST = 16'd15000;
	localparam logic [7:0]  PULSE_RST    = 8'd1;
	localparam logic [15:0] GAP_RST      = 16'd200;
	localparam logic [15:0] SETTLE_RST   = 16'd2000;

	localparam logic [7:0] LCD_HOME4    = 8'h02;
	localparam logic [7:0] LCD_FUNC     = 8'h28;
	localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
	localparam logic [7:0] LCD_ENTRY    = 8'h06;
	localparam logic [7:0] LCD_CLS      = 8'h01;
	localparam logic [7:0] LCD_ROW0     = 8'h80;
	localparam logic [7:0] LCD_ROW1     = 8'hC0;
	localparam logic [7:0] LCD_CURSOR   = 8'h0E;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_value;
		logic [1:0] row;
		logic [4:0] column;
	} lcdseq_req_t;

	typedef struct packed {
		logic [3:0]  data_nibble;
		logic        reg_select;
		logic        enable;
		logic [15:0] hold_us;
		logic        last;
	} lcdseq_step_t;

	// one entry of an action's program: a wait or a byte to send
	typedef enum logic [3:0] {
		TK_WAIT_PWR,
		TK_WAIT_SET,
		TK_CMD_IN,
		TK_DATA_IN,
		TK_ADDR,
		TK_C02,
		TK_C28,
		TK_C0C,
		TK_C06,
		TK_C01,
		TK_C80,
		TK_C0E
	} tok_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		tok_t       tok;
		logic [1:0] nib;
		logic       last;
	} lcdseq_cmd_t;

	typedef struct packed {
		logic addr_ok;
		logic out_free;
	} lcdseq_stat_t;

	function automatic tok_t tok_of(input logic [2:0] act, input logic [2:0] idx);
		tok_t t;
		t = TK_WAIT_SET;
		unique case (act)
			ACT_INIT: begin
				unique case (idx)
					3'd0: t = TK_WAIT_PWR;
					3'd1: t = TK_C02;
					3'd2: t = TK_C28;
					3'd3: t = TK_C0C;
					3'd4: t = TK_C06;
					3'd5: t = TK_C01;
					default: t = TK_WAIT_SET;
				endcase
			end
			ACT_CMD:  t = TK_CMD_IN;
			ACT_DATA: t = TK_DATA_IN;
			ACT_CLEAR: begin
				unique case (idx)
					3'd0: t = TK_C01;
					3'd1: t = TK_WAIT_SET;
					default: t = TK_C80;
				endcase
			end
			ACT_POS:     t = TK_ADDR;
			ACT_POS_CUR: t = (idx == 3'd0) ? TK_ADDR : TK_C0E;
			default:     t = TK_WAIT_SET;
		endcase
		return t;
	endfunction

	function automatic logic [2:0] last_idx(input logic [2:0] act);
		logic [2:0] n;
		unique case (act)
			ACT_INIT:    n = 3'd6;
			ACT_CLEAR:   n = 3'd2;
			ACT_POS_CUR: n = 3'd1;
			default:     n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

FILE: hdl/lcdseq_ctrl.sv
module lcdseq_ctrl
	import lcdseq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	input  logic [2:0]   req_action,
	input  lcdseq_stat_t stat,
	output logic         busy,
	output lcdseq_cmd_t  cmd
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t     state_q;
	logic [2:0] act_q;
	logic [2:0] idx_q;
	logic [1:0] nib_q;
	logic       busy_q;

	tok_t cur_tok;
	logic is_wait;
	logic tok_done;
	logic tok_last;
	logic accept;

	assign accept   = req_valid && !busy_q;
	assign cur_tok  = tok_of(act_q, idx_q);
	assign is_wait  = (cur_tok == TK_WAIT_PWR) || (cur_tok == TK_WAIT_SET);
	assign tok_done = is_wait || (nib_q == 2'd3);
	assign tok_last = (idx_q == last_idx(act_q));

	assign busy      = busy_q;
	assign cmd.load  = accept;
	assign cmd.emit  = (state_q == ST_RUN) && stat.out_free;
	assign cmd.tok   = cur_tok;
	assign cmd.nib   = nib_q;
	assign cmd.last  = tok_done && tok_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			act_q   <= ACT_INIT;
			idx_q   <= 3'd0;
			nib_q   <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req_action <= ACT_POS_CUR)
					    && !((req_action == ACT_POS) && !stat.addr_ok)) begin
						state_q <= ST_RUN;
						busy_q  <= 1'b1;
						act_q   <= req_action;
						idx_q   <= ((req_action == ACT_POS_CUR) && !stat.addr_ok)
						           ? 3'd1 : 3'd0;
						nib_q   <= 2'd0;
					end
				end
				ST_RUN: begin
					if (stat.out_free) begin
						if (tok_done) begin
							nib_q <= 2'd0;
							if (tok_last) begin
								state_q <= ST_IDLE;
								busy_q  <= 1'b0;
							end else begin
								idx_q <= idx_q + 3'd1;
							end
						end else begin
							nib_q <= nib_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: hdl/lcdseq_dp.sv
module lcdseq_dp
	import lcdseq_pkg::*;
#(
	parameter int COLUMNS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  lcdseq_req_t  req,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  lcdseq_cmd_t  cmd,
	output lcdseq_stat_t stat,
	output logic         step_valid,
	input  logic         step_stall,
	output lcdseq_step_t step
);

	localparam logic [5:0] COLS = 6'(COLUMNS);

	logic [15:0] power_up_q;
	logic [7:0]  pulse_q;
	logic [15:0] gap_q;
	logic [15:0] settle_q;

	logic [7:0] byte_q;
	logic       row1_q;
	logic [4:0] col_q;

	logic         out_valid_q;
	lcdseq_step_t out_q;

	logic [7:0]   cur_byte;
	lcdseq_step_t nxt;

	assign stat.addr_ok  = ((req.row == 2'd0) || (req.row == 2'd1))
	                       && ({1'b0, req.column} < COLS);
	assign stat.out_free = !out_valid_q || !step_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_up_q <= POWER_UP_RST;
			pulse_q    <= PULSE_RST;
			gap_q      <= GAP_RST;
			settle_q   <= SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POWER_UP: power_up_q <= cfg_data;
				CFG_PULSE:    pulse_q    <= cfg_data[7:0];
				CFG_GAP:      gap_q      <= cfg_data;
				CFG_SETTLE:   settle_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= req.byte_value;
			row1_q <= req.row[0];
			col_q  <= req.column;
		end
	end

	always_comb begin
		unique case (cmd.tok)
			TK_CMD_IN, TK_DATA_IN: cur_byte = byte_q;
			TK_ADDR:  cur_byte = (row1_q ? LCD_ROW1 : LCD_ROW0) + {3'b000, col_q};
			TK_C02:   cur_byte = LCD_HOME4;
			TK_C28:   cur_byte = LCD_FUNC;
			TK_C0C:   cur_byte = LCD_DISP_ON;
			TK_C06:   cur_byte = LCD_ENTRY;
			TK_C01:   cur_byte = LCD_CLS;
			TK_C80:   cur_byte = LCD_ROW0;
			TK_C0E:   cur_byte = LCD_CURSOR;
			default:  cur_byte = 8'h00;
		endcase

		nxt.last = cmd.last;
		if ((cmd.tok == TK_WAIT_PWR) || (cmd.tok == TK_WAIT_SET)) begin
			nxt.data_nibble = 4'h0;
			nxt.reg_select  = 1'b0;
			nxt.enable      = 1'b0;
			nxt.hold_us     = (cmd.tok == TK_WAIT_PWR) ? power_up_q : settle_q;
		end else begin
			nxt.data_nibble = cmd.nib[1] ? cur_byte[3:0] : cur_byte[7:4];
			nxt.reg_select  = (cmd.tok == TK_DATA_IN);
			nxt.enable      = !cmd.nib[0];
			if (!cmd.nib[0]) begin
				nxt.hold_us = {8'h00, pulse_q};
			end else begin
				nxt.hold_us = cmd.nib[1] ? settle_q : gap_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.out_free) begin
			out_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && stat.out_free) begin
			out_q <= nxt;
		end
	end

	assign step_valid = out_valid_q;
	assign step       = out_q;

endmodule

FILE: hdl/char_lcd_nibble_write_sequencer_core.sv
// Character LCD 4-bit write sequencer.
// Request channel (req_valid/req_stall/req): one display action per request:
// init, command byte, data char, clear-and-home, set position, position+cursor.
// Step channel (step_valid/step_stall/step): one LCD pin state per step, with
// its hold time in microseconds; last marks the final step of a request.
// A byte yields four steps (high nibble strobe, gap, low nibble strobe, settle).
// Init yields 22 steps, clear 9, command/data/position 4, position+cursor 8
// (4 when the position is out of range). A taken request is first registered
// in the controller state, then the first step enters the output register and
// one step follows per cycle while step_stall is low, as the controller walks
// the action's program one pin step at a time.
// One request is worked at a time: req_stall is high from the cycle after
// acceptance until the last step has entered the output register.
// Requests that produce no steps (bad action code, set position out of range)
// are taken and dropped without raising req_stall.
// When step_stall is high with a step held, the output register keeps it and
// the sequencer waits. Reset clears the sequencer and output valid flag and
// loads the timing registers with their defaults; cfg writes are registered.
module char_lcd_nibble_write_sequencer_core
	import lcdseq_pkg::*;
#(
	parameter int COLUMNS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_stall,
	input  lcdseq_req_t  req,
	output logic         step_valid,
	input  logic         step_stall,
	output lcdseq_step_t step,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	lcdseq_cmd_t  cmd;
	lcdseq_stat_t stat;

	lcdseq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.stat       (stat),
		.busy       (req_stall),
		.cmd        (cmd)
	);

	lcdseq_dp #(
		.COLUMNS (COLUMNS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.stat       (stat),
		.step_valid (step_valid),
		.step_stall (step_stall),
		.step       (step)
	);

endmodule

FILE: tb/testbench.sv
module testbench
	import lcdseq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS = 16;
	localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
	localparam logic [2:0] ACT_UNDEF_HI = 3'd7;
	localparam int DRAIN_LIMIT = 200000;
	localparam int LONG_HOLD = 300;

	class pin_step_scoreboard;
		lcdseq_step_t pending_steps[$];
		logic [15:0] power_up_us;
		logic [7:0] pulse_us;
		logic [15:0] gap_us;
		logic [15:0] settle_us;
		int errors;
		int checked;

		function new();
			power_up_us = POWER_UP_RST;
			pulse_us = PULSE_RST;
			gap_us = GAP_RST;
			settle_us = SETTLE_RST;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] val);
			case (idx)
				CFG_POWER_UP: power_up_us = val;
				CFG_PULSE: pulse_us = val[7:0];
				CFG_GAP: gap_us = val;
				CFG_SETTLE: settle_us = val;
				default: ;
			endcase
		endfunction

		function void push_step(logic [3:0] nib, logic rs, logic en, logic [15:0] hold);
			lcdseq_step_t s;
			s.data_nibble = nib;
			s.reg_select = rs;
			s.enable = en;
			s.hold_us = hold;
			s.last = 1'b0;
			pending_steps.push_back(s);
		endfunction

		function void push_byte(logic [7:0] b, logic rs);
			push_step(b[7:4], rs, 1'b1, {8'd0, pulse_us});
			push_step(b[7:4], rs, 1'b0, gap_us);
			push_step(b[3:0], rs, 1'b1, {8'd0, pulse_us});
			push_step(b[3:0], rs, 1'b0, settle_us);
		endfunction

		function void push_address(logic [1:0] row, logic [4:0] col);
			if (col < COLS) begin
				if (row == 2'd0)
					push_byte(LCD_ROW0 + {3'd0, col}, 1'b0);
				else if (row == 2'd1)
					push_byte(LCD_ROW1 + {3'd0, col}, 1'b0);
			end
		endfunction

		// expand one accepted request into the pin steps it must produce
		function void note_request(lcdseq_req_t r);
			int first;
			first = pending_steps.size();
			case (r.action)
				ACT_INIT: begin
					push_step(4'd0, 1'b0, 1'b0, power_up_us);
					push_byte(LCD_HOME4, 1'b0);
					push_byte(LCD_FUNC, 1'b0);
					push_byte(LCD_DISP_ON, 1'b0);
					push_byte(LCD_ENTRY, 1'b0);
					push_byte(LCD_CLS, 1'b0);
					push_step(4'd0, 1'b0, 1'b0, settle_us);
				end
				ACT_CMD: push_byte(r.byte_value, 1'b0);
				ACT_DATA: push_byte(r.byte_value, 1'b1);
				ACT_CLEAR: begin
					push_byte(LCD_CLS, 1'b0);
					push_step(4'd0, 1'b0, 1'b0, settle_us);
					push_byte(LCD_ROW0, 1'b0);
				end
				ACT_POS: push_address(r.row, r.column);
				ACT_POS_CUR: begin
					push_address(r.row, r.column);
					push_byte(LCD_CURSOR, 1'b0);
				end
				default: ;
			endcase
			if (pending_steps.size() > first)
				pending_steps[pending_steps.size() - 1].last = 1'b1;
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_step(lcdseq_step_t got);
			lcdseq_step_t want;
			if (pending_steps.size() == 0) begin
				$error("step with no request pending: nibble %0d rs %0b en %0b hold %0d last %0b",
					got.data_nibble, got.reg_select, got.enable, got.hold_us, got.last);
				errors++;
				return;
			end
			want = pending_steps.pop_front();
			checked++;
			compare_field("data_nibble", 16'(want.data_nibble), 16'(got.data_nibble));
			compare_field("reg_select", 16'(want.reg_select), 16'(got.reg_select));
			compare_field("enable", 16'(want.enable), 16'(got.enable));
			compare_field("hold_us", want.hold_us, got.hold_us);
			compare_field("last", 16'(want.last), 16'(got.last));
		endfunction

		function int pending_count();
			return pending_steps.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	lcdseq_req_t req;
	logic step_valid;
	logic step_stall;
	lcdseq_step_t step;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	pin_step_scoreboard sb;
	int gap_pct = 0;
	int stall_pct = 0;
	logic hold_toggle;
	int req_count = 0;
	int cfg_count = 0;

	char_lcd_nibble_write_sequencer_core #(.COLUMNS(COLS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.step_valid(step_valid),
		.step_stall(step_stall),
		.step(step),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				sb.note_request(req);
				req_count++;
			end
			if (step_valid && !step_stall)
				sb.check_step(step);
		end
	end

	// step receiver: random back-pressure plus a long hold-off on request
	initial begin
		logic hold_seen;
		int stall_left;
		hold_seen = 1'b0;
		stall_left = 0;
		step_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle !== hold_seen) begin
				hold_seen = hold_toggle;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				step_stall <= 1'b1;
			end else if ($urandom_range(99) < stall_pct) begin
				if ($urandom_range(7) == 0)
					stall_left = $urandom_range(40, 15);
				else
					stall_left = $urandom_range(3, 1) - 1;
				step_stall <= 1'b1;
			end else begin
				step_stall <= 1'b0;
			end
		end
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

	function automatic lcdseq_req_t make_req(logic [2:0] act, logic [7:0] b, logic [1:0] row,
		logic [4:0] col);
		lcdseq_req_t r;
		r.action = act;
		r.byte_value = b;
		r.row = row;
		r.column = col;
		return r;
	endfunction

	function automatic lcdseq_req_t random_request();
		lcdseq_req_t r;
		int pick;
		r.byte_value = 8'($urandom);
		r.row = 2'($urandom);
		r.column = 5'($urandom);
		pick = $urandom_range(99);
		if (pick < 30)
			r.action = ACT_CMD;
		else if (pick < 60)
			r.action = ACT_DATA;
		else if (pick < 72)
			r.action = ACT_POS;
		else if (pick < 84)
			r.action = ACT_POS_CUR;
		else if (pick < 90)
			r.action = ACT_CLEAR;
		else if (pick < 95)
			r.action = ACT_INIT;
		else
			r.action = ($urandom_range(1) == 0) ? ACT_UNDEF_LO : ACT_UNDEF_HI;
		// keep most positions on screen
		if ((r.action == ACT_POS || r.action == ACT_POS_CUR) && $urandom_range(3) != 0) begin
			r.row = 2'($urandom_range(1));
			r.column = 5'($urandom_range(COLS - 1));
		end
		return r;
	endfunction

	task automatic send_request(lcdseq_req_t r);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic idle_gap();
		int n;
		n = 0;
		if ($urandom_range(99) < gap_pct)
			n = ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_all_steps();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (sb.pending_count() != 0 && waited < DRAIN_LIMIT);
		// then let dropped requests and the output register settle
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_count++;
	endtask

	task automatic set_timing(logic [15:0] pwr, logic [15:0] pulse, logic [15:0] gap,
		logic [15:0] settle);
		write_reg(CFG_POWER_UP, pwr);
		write_reg(CFG_PULSE, pulse);
		write_reg(CFG_GAP, gap);
		write_reg(CFG_SETTLE, settle);
		cfg_we <= 1'b0;
	endtask

	task automatic set_random_timing();
		set_timing(16'($urandom), {8'($urandom), 8'($urandom_range(255, 1))},
			16'($urandom), 16'($urandom));
	endtask

	task automatic run_directed();
		lcdseq_req_t list[$];
		list.push_back(make_req(ACT_INIT, 8'h00, 2'd0, 5'd0));
		list.push_back(make_req(ACT_CMD, 8'h00, 2'd0, 5'd0));
		list.push_back(make_req(ACT_CMD, 8'hFF, 2'd3, 5'd31));
		list.push_back(make_req(ACT_DATA, 8'h00, 2'd0, 5'd0));
		list.push_back(make_req(ACT_DATA, 8'hFF, 2'd3, 5'd31));
		list.push_back(make_req(ACT_DATA, 8'h5A, 2'd1, 5'd10));
		list.push_back(make_req(ACT_CLEAR, 8'hA5, 2'd2, 5'd21));
		list.push_back(make_req(ACT_POS, 8'h00, 2'd0, 5'd0));
		list.push_back(make_req(ACT_POS, 8'hFF, 2'd1, 5'(COLS - 1)));
		list.push_back(make_req(ACT_POS, 8'h00, 2'd0, 5'(COLS)));
		list.push_back(make_req(ACT_POS, 8'h00, 2'd2, 5'd3));
		list.push_back(make_req(ACT_POS, 8'h00, 2'd3, 5'd31));
		list.push_back(make_req(ACT_POS, 8'h00, 2'd1, 5'd31));
		list.push_back(make_req(ACT_POS_CUR, 8'h00, 2'd1, 5'd0));
		list.push_back(make_req(ACT_POS_CUR, 8'hFF, 2'd0, 5'(COLS - 1)));
		list.push_back(make_req(ACT_POS_CUR, 8'h00, 2'd2, 5'd5));
		list.push_back(make_req(ACT_POS_CUR, 8'h00, 2'd0, 5'd31));
		list.push_back(make_req(ACT_UNDEF_LO, 8'h3C, 2'd1, 5'd2));
		list.push_back(make_req(ACT_UNDEF_HI, 8'hFF, 2'd3, 5'd31));
		list.push_back(make_req(ACT_CMD, 8'h0F, 2'd0, 5'd0));
		foreach (list[i]) begin
			send_request(list[i]);
			idle_gap();
		end
	endtask

	task automatic run_random(int count);
		repeat (count) begin
			send_request(random_request());
			idle_gap();
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_POWER_UP;
		cfg_data <= '0;
		hold_toggle <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_all_steps();

		set_timing(16'd0, 16'd1, 16'd0, 16'd0);
		gap_pct = 30;
		stall_pct = 30;
		run_directed();
		wait_all_steps();

		set_timing(16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF);
		run_random(40);
		wait_all_steps();

		// receiver holds off while requests keep coming back to back
		set_random_timing();
		gap_pct = 0;
		hold_toggle <= 1'b1;
		run_random(30);
		wait_all_steps();

		for (int ph = 0; ph < 5; ph++) begin
			set_random_timing();
			gap_pct = (ph % 2 == 0) ? 0 : 40;
			stall_pct = (ph == 1) ? 0 : 15 * ph;
			run_random(48);
			wait_all_steps();
		end

		if (sb.pending_count() != 0) begin
			$error("%0d expected steps never arrived", sb.pending_count());
			sb.errors++;
		end
		$display("Covered %0d requests over all actions, undefined codes and off-screen positions,",
			req_count);
		$display("%0d pin steps checked under %0d timing register writes", sb.checked, cfg_count);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
